// ===== design/c20_pkg.sv =====
// shared types, constants and round functions of the chacha20 block function
// no dependencies; imported by every module of the block
package c20_pkg;

    localparam int WORD_W = 32;
    localparam int PAIRS  = 8;
    localparam int PAIR_W = 64;
    localparam int IDX_W  = $clog2(PAIRS);

    typedef logic [WORD_W-1:0] t_word;

    // word k of the state sits at bits 32k+31..32k, so pair i is bits 64i+63..64i
    typedef logic [15:0][WORD_W-1:0] t_state;
    typedef logic [PAIRS-1:0][PAIR_W-1:0] t_pairs;

    typedef struct packed {
        t_word [7:0] key;
        t_word       counter;
        t_word [2:0] nonce;
    } t_item;

    typedef struct packed {
        t_word a;
        t_word b;
        t_word c;
        t_word d;
    } t_quad;

    localparam t_word SIGMA_0 = 32'h6170_7865;
    localparam t_word SIGMA_1 = 32'h3320_646e;
    localparam t_word SIGMA_2 = 32'h7962_2d32;
    localparam t_word SIGMA_3 = 32'h6b20_6574;

    localparam int ROT_A = 16;
    localparam int ROT_B = 12;
    localparam int ROT_C = 8;
    localparam int ROT_D = 7;

    // state word indices a, b, c, d of each quarter round; column half then diagonal half
    localparam logic [3:0] QR_IDX [2][4][4] = '{
        '{ '{4'd0, 4'd4, 4'd8,  4'd12}, '{4'd1, 4'd5, 4'd9,  4'd13},
           '{4'd2, 4'd6, 4'd10, 4'd14}, '{4'd3, 4'd7, 4'd11, 4'd15} },
        '{ '{4'd0, 4'd5, 4'd10, 4'd15}, '{4'd1, 4'd6, 4'd11, 4'd12},
           '{4'd2, 4'd7, 4'd8,  4'd13}, '{4'd3, 4'd4, 4'd9,  4'd14} }
    };

    function automatic t_word rotl(t_word x, int n);
        return (x << n) | (x >> (WORD_W - n));
    endfunction

    function automatic t_quad quarter(t_word a_in, t_word b_in, t_word c_in, t_word d_in);
        t_word a;
        t_word b;
        t_word c;
        t_word d;
        a = a_in;
        b = b_in;
        c = c_in;
        d = d_in;
        a = a + b; d = rotl(d ^ a, ROT_A);
        c = c + d; b = rotl(b ^ c, ROT_B);
        a = a + b; d = rotl(d ^ a, ROT_C);
        c = c + d; b = rotl(b ^ c, ROT_D);
        return '{a: a, b: b, c: c, d: d};
    endfunction

    // one column round or one diagonal round: four independent quarter rounds
    function automatic t_state half_round(t_state s, logic diag);
        t_state r;
        t_quad  q;
        int     h;
        r = s;
        h = diag ? 1 : 0;
        for (int i = 0; i < 4; i++) begin
            q = quarter(s[QR_IDX[h][i][0]], s[QR_IDX[h][i][1]],
                        s[QR_IDX[h][i][2]], s[QR_IDX[h][i][3]]);
            r[QR_IDX[h][i][0]] = q.a;
            r[QR_IDX[h][i][1]] = q.b;
            r[QR_IDX[h][i][2]] = q.c;
            r[QR_IDX[h][i][3]] = q.d;
        end
        return r;
    endfunction

    function automatic t_state init_state(t_item it);
        t_state s;
        s[0] = SIGMA_0;
        s[1] = SIGMA_1;
        s[2] = SIGMA_2;
        s[3] = SIGMA_3;
        for (int i = 0; i < 8; i++) begin
            s[4 + i] = it.key[i];
        end
        s[12] = it.counter;
        s[13] = it.nonce[0];
        s[14] = it.nonce[1];
        s[15] = it.nonce[2];
        return s;
    endfunction

    function automatic t_state add_states(t_state x, t_state y);
        t_state s;
        for (int i = 0; i < 16; i++) begin
            s[i] = x[i] + y[i];
        end
        return s;
    endfunction

endpackage

// ===== design/c20_front.sv =====
// front end: accepts key, nonce and counter words into a two-entry queue
// depends on c20_pkg
module c20_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            push,
    output logic            full,
    input  logic [63:0]     i_key_words_0_1,
    input  logic [63:0]     i_key_words_2_3,
    input  logic [63:0]     i_key_words_4_5,
    input  logic [63:0]     i_key_words_6_7,
    input  logic [63:0]     i_nonce_words_0_1,
    input  logic [31:0]     i_nonce_word_2,
    input  logic [31:0]     i_block_counter,
    output logic            o_valid,
    output c20_pkg::t_item  o_item,
    input  logic            i_take
);
    import c20_pkg::*;

    t_item      r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_count;
    t_item      n_item;
    logic       w_push;
    logic       w_take;

    always_comb begin
        n_item.key[0]   = i_key_words_0_1[31:0];
        n_item.key[1]   = i_key_words_0_1[63:32];
        n_item.key[2]   = i_key_words_2_3[31:0];
        n_item.key[3]   = i_key_words_2_3[63:32];
        n_item.key[4]   = i_key_words_4_5[31:0];
        n_item.key[5]   = i_key_words_4_5[63:32];
        n_item.key[6]   = i_key_words_6_7[31:0];
        n_item.key[7]   = i_key_words_6_7[63:32];
        n_item.counter  = i_block_counter;
        n_item.nonce[0] = i_nonce_words_0_1[31:0];
        n_item.nonce[1] = i_nonce_words_0_1[63:32];
        n_item.nonce[2] = i_nonce_word_2;
    end

    assign full    = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_item  = r_mem[r_rd];
    assign w_push  = push && !full;
    assign w_take  = i_take && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr <= !r_wr;
            end
            if (w_take) begin
                r_rd <= !r_rd;
            end
            case ({w_push, w_take})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= n_item;
        end
    end

endmodule

// ===== design/c20_core.sv =====
// round engine: one column or diagonal round a cycle, then the feed-forward add
// depends on c20_pkg
module c20_core #(
    parameter int DOUBLE_ROUNDS = 10
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  c20_pkg::t_item  i_item,
    output logic            o_take,
    output logic            o_out_valid,
    output c20_pkg::t_state o_out_words,
    input  logic            i_out_ready
);
    import c20_pkg::*;

    localparam int HALF_ROUNDS = 2 * DOUBLE_ROUNDS;
    localparam int RND_W       = (HALF_ROUNDS > 1) ? $clog2(HALF_ROUNDS) : 1;
    localparam logic [RND_W-1:0] RND_LAST = RND_W'(HALF_ROUNDS - 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_DONE = 3'b100
    } t_core_state;

    t_core_state      r_state, n_state;
    logic [RND_W-1:0] r_round, n_round;
    t_state           r_work, n_work;
    t_state           r_init, n_init;

    assign o_out_valid = (r_state == S_DONE);
    assign o_out_words = add_states(r_work, r_init);

    always_comb begin
        n_state = r_state;
        n_round = r_round;
        n_work  = r_work;
        n_init  = r_init;
        o_take  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_take  = 1'b1;
                    n_work  = init_state(i_item);
                    n_init  = init_state(i_item);
                    n_round = '0;
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                // even steps are column rounds, odd steps diagonal rounds
                n_work = half_round(r_work, r_round[0]);
                if (r_round == RND_LAST) begin
                    n_state = S_DONE;
                end else begin
                    n_round = r_round + 1'b1;
                end
            end
            S_DONE: begin
                if (i_out_ready) begin
                    if (i_valid) begin
                        o_take  = 1'b1;
                        n_work  = init_state(i_item);
                        n_init  = init_state(i_item);
                        n_round = '0;
                        n_state = S_RUN;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_round <= '0;
        end else begin
            r_state <= n_state;
            r_round <= n_round;
        end
    end

    always_ff @(posedge i_clk) begin
        r_work <= n_work;
        r_init <= n_init;
    end

endmodule

// ===== design/c20_out.sv =====
// result buffer: holds one keystream block and shifts it out a word at a time
// depends on c20_pkg
module c20_out (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_load,
    input  c20_pkg::t_state           i_words,
    output logic                      o_ready,
    output logic                      empty,
    input  logic                      pop,
    output logic [63:0]               o_keystream_pair,
    output logic [c20_pkg::IDX_W-1:0] o_pair_index,
    output logic                      o_last_pair
);
    import c20_pkg::*;

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(PAIRS - 1);

    t_pairs           r_pairs;
    logic [IDX_W-1:0] r_idx;
    logic             r_valid;
    logic             w_pop;
    logic             w_load;

    assign empty            = !r_valid;
    assign o_keystream_pair = r_pairs[0];
    assign o_pair_index     = r_idx;
    assign o_last_pair      = (r_idx == IDX_LAST);
    assign w_pop            = pop && r_valid;
    // a new block may land in the cycle its predecessor's last word leaves
    assign o_ready          = !r_valid || (w_pop && o_last_pair);
    assign w_load           = i_load && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (w_load) begin
            r_valid <= 1'b1;
            r_idx   <= '0;
        end else if (w_pop) begin
            r_valid <= !o_last_pair;
            r_idx   <= r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_pairs <= t_pairs'(i_words);
        end else if (w_pop) begin
            r_pairs <= {{PAIR_W{1'b0}}, r_pairs[PAIRS-1:1]};
        end
    end

endmodule

// ===== design/chacha20_block_function.sv =====
// chacha20 block function: one 64-byte keystream block per item, as eight 64-bit words
// the first word shows once the engine has run all its rounds and the block sits in the result buffer
// the round engine does one column or diagonal round a cycle and sets the block rate; the
// eight result words drain meanwhile, one a cycle while pop is held high
// reset: synchronous, active low; empties the input queue and result buffer, engine idles
// depends on c20_pkg, c20_front, c20_core, c20_out
module chacha20_block_function #(
    parameter int DOUBLE_ROUNDS = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [63:0] i_key_words_0_1,
    input  logic [63:0] i_key_words_2_3,
    input  logic [63:0] i_key_words_4_5,
    input  logic [63:0] i_key_words_6_7,
    input  logic [63:0] i_nonce_words_0_1,
    input  logic [31:0] i_nonce_word_2,
    input  logic [31:0] i_block_counter,
    output logic        empty,
    input  logic        pop,
    output logic [63:0] o_keystream_pair,
    output logic [2:0]  o_pair_index,
    output logic        o_last_pair
);
    import c20_pkg::*;

    logic   w_item_valid;
    t_item  w_item;
    logic   w_take;
    logic   w_blk_valid;
    t_state w_blk_words;
    logic   w_blk_ready;

    c20_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .push              (push),
        .full              (full),
        .i_key_words_0_1   (i_key_words_0_1),
        .i_key_words_2_3   (i_key_words_2_3),
        .i_key_words_4_5   (i_key_words_4_5),
        .i_key_words_6_7   (i_key_words_6_7),
        .i_nonce_words_0_1 (i_nonce_words_0_1),
        .i_nonce_word_2    (i_nonce_word_2),
        .i_block_counter   (i_block_counter),
        .o_valid           (w_item_valid),
        .o_item            (w_item),
        .i_take            (w_take)
    );

    c20_core #(
        .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_item_valid),
        .i_item      (w_item),
        .o_take      (w_take),
        .o_out_valid (w_blk_valid),
        .o_out_words (w_blk_words),
        .i_out_ready (w_blk_ready)
    );

    c20_out u_out (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_load           (w_blk_valid),
        .i_words          (w_blk_words),
        .o_ready          (w_blk_ready),
        .empty            (empty),
        .pop              (pop),
        .o_keystream_pair (o_keystream_pair),
        .o_pair_index     (o_pair_index),
        .o_last_pair      (o_last_pair)
    );

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// self-checking bench for chacha20_block_function: directed table, then random key/nonce/counter
// words, each block predicted by a local chacha20 model; needs the block, its submodules and its package

module testbench;

    localparam int DOUBLE_ROUNDS = 10;
    localparam int DIRECTED_N    = 13;
    localparam int RANDOM_N      = 320;
    localparam int SETTLE_N      = 50;
    localparam int DRAIN_CYCLES  = 40;
    localparam int LIMIT_CYCLES  = 400000;

    typedef logic [31:0] word_t;
    typedef logic [15:0][31:0] cc_state_t;
    typedef logic [7:0][63:0] block_pairs_t;

    typedef struct packed {
        logic [63:0] key01;
        logic [63:0] key23;
        logic [63:0] key45;
        logic [63:0] key67;
        logic [63:0] nonce01;
        logic [31:0] nonce2;
        logic [31:0] counter;
    } block_req_t;

    typedef struct packed {
        logic [63:0] pair;
        logic [2:0]  idx;
        logic        last;
    } slice_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        pop = 1'b0;
    logic [63:0] i_key_words_0_1 = '0;
    logic [63:0] i_key_words_2_3 = '0;
    logic [63:0] i_key_words_4_5 = '0;
    logic [63:0] i_key_words_6_7 = '0;
    logic [63:0] i_nonce_words_0_1 = '0;
    logic [31:0] i_nonce_word_2 = '0;
    logic [31:0] i_block_counter = '0;
    logic        full;
    logic        empty;
    logic [63:0] o_keystream_pair;
    logic [2:0]  o_pair_index;
    logic        o_last_pair;

    slice_t slices_due[$];
    int     n_fail = 0;
    int     cycle_count = 0;
    int     gap_pct = 0;
    int     pop_stall_pct = 0;
    int     pop_hold = 0;
    logic   settle = 1'b0;

    chacha20_block_function #(
        .DOUBLE_ROUNDS(DOUBLE_ROUNDS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .push(push),
        .full(full),
        .i_key_words_0_1(i_key_words_0_1),
        .i_key_words_2_3(i_key_words_2_3),
        .i_key_words_4_5(i_key_words_4_5),
        .i_key_words_6_7(i_key_words_6_7),
        .i_nonce_words_0_1(i_nonce_words_0_1),
        .i_nonce_word_2(i_nonce_word_2),
        .i_block_counter(i_block_counter),
        .empty(empty),
        .pop(pop),
        .o_keystream_pair(o_keystream_pair),
        .o_pair_index(o_pair_index),
        .o_last_pair(o_last_pair)
    );

    always #5 i_clk = ~i_clk;

    function automatic word_t rol32(word_t v, int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function automatic cc_state_t mix_quarter(cc_state_t s, int a, int b, int c, int d);
        s[a] = s[a] + s[b]; s[d] = rol32(s[d] ^ s[a], 16);
        s[c] = s[c] + s[d]; s[b] = rol32(s[b] ^ s[c], 12);
        s[a] = s[a] + s[b]; s[d] = rol32(s[d] ^ s[a], 8);
        s[c] = s[c] + s[d]; s[b] = rol32(s[b] ^ s[c], 7);
        return s;
    endfunction

    function automatic block_pairs_t chacha_keystream(block_req_t rq);
        cc_state_t    init;
        cc_state_t    work;
        block_pairs_t ks;
        init[0]  = 32'h6170_7865;
        init[1]  = 32'h3320_646e;
        init[2]  = 32'h7962_2d32;
        init[3]  = 32'h6b20_6574;
        init[4]  = rq.key01[31:0];
        init[5]  = rq.key01[63:32];
        init[6]  = rq.key23[31:0];
        init[7]  = rq.key23[63:32];
        init[8]  = rq.key45[31:0];
        init[9]  = rq.key45[63:32];
        init[10] = rq.key67[31:0];
        init[11] = rq.key67[63:32];
        init[12] = rq.counter;
        init[13] = rq.nonce01[31:0];
        init[14] = rq.nonce01[63:32];
        init[15] = rq.nonce2;
        work = init;
        for (int r = 0; r < DOUBLE_ROUNDS; r++) begin
            work = mix_quarter(work, 0, 4, 8, 12);
            work = mix_quarter(work, 1, 5, 9, 13);
            work = mix_quarter(work, 2, 6, 10, 14);
            work = mix_quarter(work, 3, 7, 11, 15);
            work = mix_quarter(work, 0, 5, 10, 15);
            work = mix_quarter(work, 1, 6, 11, 12);
            work = mix_quarter(work, 2, 7, 8, 13);
            work = mix_quarter(work, 3, 4, 9, 14);
        end
        for (int i = 0; i < 16; i++) begin
            work[i] = work[i] + init[i];
        end
        for (int i = 0; i < 8; i++) begin
            ks[i] = {work[2*i+1], work[2*i]};
        end
        return ks;
    endfunction

    // two times in five plain random, otherwise zero, all ones or a single bit
    function automatic logic [63:0] pick_field();
        logic [63:0] v;
        case ($urandom_range(0, 4))
            0: begin
                v = '0;
            end
            1: begin
                v = '1;
            end
            2: begin
                v = 64'h1 << $urandom_range(0, 63);
            end
            default: begin
                v = {$urandom, $urandom};
            end
        endcase
        return v;
    endfunction

    function automatic block_req_t make_random_req();
        block_req_t  rq;
        logic [63:0] t;
        if ($urandom_range(0, 99) < 70) begin
            rq = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        end else begin
            rq.key01   = pick_field();
            rq.key23   = pick_field();
            rq.key45   = pick_field();
            rq.key67   = pick_field();
            rq.nonce01 = pick_field();
            t = pick_field();
            rq.nonce2  = t[31:0];
            t = pick_field();
            rq.counter = t[63:32];
        end
        return rq;
    endfunction

    task automatic offer_block(input block_req_t rq);
        @(negedge i_clk);
        push              = 1'b1;
        i_key_words_0_1   = rq.key01;
        i_key_words_2_3   = rq.key23;
        i_key_words_4_5   = rq.key45;
        i_key_words_6_7   = rq.key67;
        i_nonce_words_0_1 = rq.nonce01;
        i_nonce_word_2    = rq.nonce2;
        i_block_counter   = rq.counter;
        @(posedge i_clk);
        while (full !== 1'b0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic idle_sender(input int n);
        repeat (n) begin
            @(negedge i_clk);
            push = 1'b0;
        end
    endtask

    // reader side: drops pop in random stall bursts, whose length pop_hold sets
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (settle) begin
            pop <= 1'b1;
        end else if (pop_hold > 0) begin
            pop <= 1'b0;
            pop_hold <= pop_hold - 1;
        end else if ($urandom_range(0, 99) < pop_stall_pct) begin
            pop <= 1'b0;
            pop_hold <= $urandom_range(0, 5);
        end else begin
            pop <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : scoreboard
        block_pairs_t ks;
        slice_t       want;
        if (i_rst_n && push && !full) begin
            ks = chacha_keystream({i_key_words_0_1, i_key_words_2_3, i_key_words_4_5,
                                   i_key_words_6_7, i_nonce_words_0_1, i_nonce_word_2,
                                   i_block_counter});
            for (int k = 0; k < 8; k++) begin
                slices_due.push_back({ks[k], k[2:0], k == 7});
            end
        end
        if (i_rst_n && pop && !empty) begin
            if (slices_due.size() == 0) begin
                if (n_fail < 10) begin
                    $display("unexpected word: pair %h index %0d last %b",
                             o_keystream_pair, o_pair_index, o_last_pair);
                end
                n_fail++;
            end else begin
                want = slices_due.pop_front();
                if (o_keystream_pair !== want.pair || o_pair_index !== want.idx ||
                    o_last_pair !== want.last) begin
                    if (n_fail < 10) begin
                        $display("mismatch: expected %h/%0d/%b got %h/%0d/%b",
                                 want.pair, want.idx, want.last,
                                 o_keystream_pair, o_pair_index, o_last_pair);
                    end
                    n_fail++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        block_req_t rows [DIRECTED_N];
        // key01, key23, key45, key67, nonce01, nonce2, counter
        rows[0]  = '0;
        rows[1]  = '1;
        // key bytes 00..1f, nonce 00 00 00 09 00 00 00 4a 00 00 00 00, counter 1
        rows[2]  = {64'h0706_0504_0302_0100, 64'h0f0e_0d0c_0b0a_0908,
                    64'h1716_1514_1312_1110, 64'h1f1e_1d1c_1b1a_1918,
                    64'h4a00_0000_0900_0000, 32'h0, 32'h1};
        // counter at its top value is used as is, never wrapped
        rows[3]  = {64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 32'h0, 32'hffff_ffff};
        rows[4]  = {64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff,
                    64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff,
                    64'h0, 32'h0, 32'h0};
        rows[5]  = {64'h5555_5555_5555_5555, 64'h5555_5555_5555_5555,
                    64'h5555_5555_5555_5555, 64'h5555_5555_5555_5555,
                    64'haaaa_aaaa_aaaa_aaaa, 32'haaaa_aaaa, 32'h5555_5555};
        rows[6]  = {64'haaaa_aaaa_aaaa_aaaa, 64'haaaa_aaaa_aaaa_aaaa,
                    64'haaaa_aaaa_aaaa_aaaa, 64'haaaa_aaaa_aaaa_aaaa,
                    64'h5555_5555_5555_5555, 32'h5555_5555, 32'haaaa_aaaa};
        rows[7]  = {64'h1, 64'h0, 64'h0, 64'h0, 64'h0, 32'h0, 32'h0};
        rows[8]  = {64'h0, 64'h0, 64'h0, 64'h8000_0000_0000_0000, 64'h0, 32'h0, 32'h0};
        rows[9]  = {64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 32'h8000_0000, 32'h1};
        rows[10] = {64'h0, 64'h0, 64'h0, 64'h0, 64'h8000_0000_0000_0001, 32'h0, 32'h0};
        rows[11] = {64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 32'h0, 32'h8000_0000};
        rows[12] = {64'h0, 64'h8000_0000_0000_0001, 64'h8000_0000_0000_0001,
                    64'h0, 64'hffff_ffff_0000_0000, 32'h0000_0001, 32'hffff_fffe};

        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        gap_pct = 25;
        pop_stall_pct = 25;
        for (int n = 0; n < DIRECTED_N; n++) begin
            offer_block(rows[n]);
            if ($urandom_range(0, 99) < gap_pct) begin
                idle_sender($urandom_range(1, 6));
            end
        end

        // hold off until the pipeline has fully drained
        idle_sender(1);
        while (slices_due.size() != 0) begin
            @(negedge i_clk);
        end

        for (int n = 0; n < RANDOM_N; n++) begin
            if (n % 40 == 0) begin
                case ($urandom_range(0, 2))
                    0: begin
                        gap_pct = 0;
                        pop_stall_pct = 0;
                    end
                    1: begin
                        gap_pct = 25;
                        pop_stall_pct = 30;
                    end
                    default: begin
                        gap_pct = 60;
                        pop_stall_pct = 10;
                    end
                endcase
            end
            if (n >= RANDOM_N - SETTLE_N) begin
                settle = 1'b1;
            end
            offer_block(make_random_req());
            if (!settle && $urandom_range(0, 99) < gap_pct) begin
                idle_sender($urandom_range(1, 6));
            end
        end
        idle_sender(1);

        while (slices_due.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (n_fail == 0 && slices_due.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/c20_pkg.sv
design/c20_front.sv
design/c20_core.sv
design/c20_out.sv
design/chacha20_block_function.sv
sim/testbench.sv
